// ----- rtl/esc_pkg.sv -----
package esc_pkg;

    localparam int DEFAULT_MAX_LINE = 256;
    localparam int BYTE_W           = 8;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_AT    = 8'd64;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'd46;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'd95;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'd45;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOCAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DOMAIN = 1'b1;

    localparam logic [BYTE_W-1:0] RESET_MAX_LOCAL  = 8'd32;
    localparam logic [BYTE_W-1:0] RESET_MAX_DOMAIN = 8'd64;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] start;
        logic [BYTE_W-1:0] length;
    } t_scan_result;

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return (c inside {[8'd97:8'd122], [8'd65:8'd90], [8'd48:8'd57]});
    endfunction

    function automatic logic is_local_char(input logic [BYTE_W-1:0] c);
        return is_alnum(c) || (c inside {CH_DOT, CH_UNDER});
    endfunction

    function automatic logic is_domain_char(input logic [BYTE_W-1:0] c);
        return is_alnum(c) || (c inside {CH_DOT, CH_DASH});
    endfunction

    function automatic logic [BYTE_W-1:0] sat_inc(input logic [BYTE_W-1:0] v);
        return (v == '1) ? v : v + 8'd1;
    endfunction

endpackage

// ----- rtl/esc_text_if.sv -----
interface esc_text_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::BYTE_W-1:0]   text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// ----- rtl/esc_addr_if.sv -----
interface esc_addr_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::BYTE_W-1:0]   addr_start;
    logic [esc_pkg::BYTE_W-1:0]   addr_length;

    modport source (output valid, output addr_start, output addr_length, input ready);
    modport sink   (input valid, input addr_start, input addr_length, output ready);
endinterface

// ----- rtl/email_address_scanner_unit.sv -----
// Email address scanner.
// i_text carries one text byte per word; byte 10 ends a line. o_addr carries
// one word per found address: start position in the line and total length
// (local part, at sign and domain). An address is reported when the byte
// that ends its domain is scanned, so a line without a closing byte keeps
// its last address open.
// The limits on local and domain length are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while no text
// is in flight, as the block does not enforce it. Throughput: one byte per
// cycle while the receiver takes results. The accepted byte sits in the
// input register and is classified, with the small counters updated,
// before the result register loads.
// Reset clears both registers, the line position and all run counters, and
// loads the length limits to 32 and 64.
// When the receiver stalls, the result word holds; the input register takes
// at most one more byte, then i_text.ready drops until the result is taken.
module email_address_scanner_unit #(
    parameter int MAX_LINE = esc_pkg::DEFAULT_MAX_LINE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    esc_text_if.sink                        i_text,
    esc_addr_if.source                      o_addr,
    input  logic                            i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [esc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [esc_pkg::BYTE_W-1:0]  r_max_local;
    logic [esc_pkg::BYTE_W-1:0]  r_max_domain;

    logic                        w_in_valid;
    logic [esc_pkg::BYTE_W-1:0]  w_in_byte;
    logic                        w_room;
    logic                        w_adv;
    esc_pkg::t_scan_result       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_local  <= esc_pkg::RESET_MAX_LOCAL;
            r_max_domain <= esc_pkg::RESET_MAX_DOMAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                esc_pkg::CFG_MAX_LOCAL:  r_max_local  <= i_cfg_data;
                esc_pkg::CFG_MAX_DOMAIN: r_max_domain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_adv = w_in_valid && w_room;

    esc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_room  (w_room),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    esc_scan #(
        .MAX_LINE (MAX_LINE)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_byte       (w_in_byte),
        .i_max_local  (r_max_local),
        .i_max_domain (r_max_domain),
        .o_res        (w_res)
    );

    esc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_res   (w_res),
        .o_addr  (o_addr),
        .o_room  (w_room)
    );

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_addr.valid |-> o_addr.addr_length >= 8'd3)
        else $error("address length below three");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && o_addr.valid && !o_addr.ready) |=> w_in_valid)
        else $error("input word dropped while result stalled");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_addr.valid) |-> $past(w_adv && w_res.hit))
        else $error("result appeared without a scanned byte");

endmodule

// ----- rtl/esc_in_reg.sv -----
module esc_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    esc_text_if.sink                    i_text,
    input  logic                        i_room,
    output logic                        o_valid,
    output logic [esc_pkg::BYTE_W-1:0]  o_byte
);

    logic                        r_valid;
    logic                        n_valid;
    logic [esc_pkg::BYTE_W-1:0]  r_byte;
    logic                        w_load;

    assign i_text.ready = !r_valid || i_room;
    assign w_load       = i_text.valid && i_text.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_room) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_text.text_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- rtl/esc_scan.sv -----
module esc_scan #(
    parameter int MAX_LINE = esc_pkg::DEFAULT_MAX_LINE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [esc_pkg::BYTE_W-1:0]  i_byte,
    input  logic [esc_pkg::BYTE_W-1:0]  i_max_local,
    input  logic [esc_pkg::BYTE_W-1:0]  i_max_domain,
    output esc_pkg::t_scan_result       o_res
);

    localparam int LPW = $clog2(MAX_LINE + 1);

    logic [LPW-1:0]              r_line_pos,   n_line_pos;
    logic [esc_pkg::BYTE_W-1:0]  r_local_run,  n_local_run;
    logic                        r_dom_active, n_dom_active;
    logic [esc_pkg::BYTE_W-1:0]  r_dom_run,    n_dom_run;
    logic [esc_pkg::BYTE_W-1:0]  r_pend_start, n_pend_start;
    logic [esc_pkg::BYTE_W-1:0]  r_pend_local, n_pend_local;

    logic                        w_fin_ok;
    logic [esc_pkg::BYTE_W:0]    w_len_sum;
    logic [esc_pkg::BYTE_W-1:0]  w_len;

    assign w_fin_ok  = (r_dom_run != '0) && (r_dom_run <= i_max_domain);
    assign w_len_sum = {1'b0, r_pend_local} + 9'd1 + {1'b0, r_dom_run};
    assign w_len     = w_len_sum[esc_pkg::BYTE_W] ? '1 : w_len_sum[esc_pkg::BYTE_W-1:0];

    always_comb begin
        n_line_pos   = r_line_pos;
        n_local_run  = r_local_run;
        n_dom_active = r_dom_active;
        n_dom_run    = r_dom_run;
        n_pend_start = r_pend_start;
        n_pend_local = r_pend_local;
        o_res.hit    = 1'b0;
        o_res.start  = r_pend_start;
        o_res.length = w_len;
        if (i_byte == esc_pkg::CH_LF) begin
            o_res.hit    = r_dom_active && w_fin_ok;
            n_line_pos   = '0;
            n_local_run  = '0;
            n_dom_active = 1'b0;
            n_dom_run    = '0;
        end else if (r_line_pos != LPW'(MAX_LINE)) begin
            if (r_dom_active) begin
                if (esc_pkg::is_domain_char(i_byte)) begin
                    n_dom_run = esc_pkg::sat_inc(r_dom_run);
                end else begin
                    o_res.hit    = w_fin_ok;
                    n_dom_active = 1'b0;
                    n_dom_run    = '0;
                end
            end else if (i_byte == esc_pkg::CH_AT && r_local_run != '0
                         && r_local_run <= i_max_local) begin
                n_dom_active = 1'b1;
                n_dom_run    = '0;
                n_pend_local = r_local_run;
                n_pend_start = esc_pkg::BYTE_W'(r_line_pos) - r_local_run;
            end
            n_local_run = esc_pkg::is_local_char(i_byte) ? esc_pkg::sat_inc(r_local_run) : '0;
            n_line_pos  = r_line_pos + LPW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos   <= '0;
            r_local_run  <= '0;
            r_dom_active <= 1'b0;
            r_dom_run    <= '0;
        end else if (i_adv) begin
            r_line_pos   <= n_line_pos;
            r_local_run  <= n_local_run;
            r_dom_active <= n_dom_active;
            r_dom_run    <= n_dom_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pend_start <= n_pend_start;
            r_pend_local <= n_pend_local;
        end
    end

endmodule

// ----- rtl/esc_out_reg.sv -----
module esc_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  esc_pkg::t_scan_result  i_res,
    esc_addr_if.source             o_addr,
    output logic                   o_room
);

    logic                        r_valid;
    logic                        n_valid;
    logic [esc_pkg::BYTE_W-1:0]  r_start;
    logic [esc_pkg::BYTE_W-1:0]  r_length;

    assign o_room = !r_valid || o_addr.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_adv) begin
            n_valid = i_res.hit;
        end else if (o_addr.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_res.hit) begin
            r_start  <= i_res.start;
            r_length <= i_res.length;
        end
    end

    assign o_addr.valid       = r_valid;
    assign o_addr.addr_start  = r_start;
    assign o_addr.addr_length = r_length;

endmodule
